/* hw/rtl/ssr_pkg.sv */
// Package for the segment screen rotator: payload structs, op and register codes,
// the character font and sizing constants. Depends on nothing; every other file imports it.
package ssr_pkg;

   localparam int NUM_SCREENS  = 3;
   localparam int SCREEN_IDX_W = 2;
   localparam int WORD_W       = 16;
   localparam int DWELL_W      = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int CHAR_W       = 8;

   localparam logic [DWELL_W-1:0]      DWELL_RESET = 8'd50;
   // An empty screen is skipped to the next one, but that skip wraps at this index.
   localparam logic [SCREEN_IDX_W-1:0] SKIP_WRAP   = 2'd2;

   localparam logic [WORD_W-1:0] COMMA_A = 16'h0080;
   localparam logic [WORD_W-1:0] COMMA_B = 16'h0001;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_SET_CHARS = 2'd1,
      OP_SET_RAW   = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DWELL_FIRST  = 2'd0,
      CSR_DWELL_SECOND = 2'd1,
      CSR_DWELL_THIRD  = 2'd2
   } csr_index_type;

   typedef struct packed {
      op_type                  op;
      logic [SCREEN_IDX_W-1:0] screen_sel;
      logic [CHAR_W-1:0]       char0;
      logic [CHAR_W-1:0]       char1;
      logic [CHAR_W-1:0]       char2;
      logic [CHAR_W-1:0]       char3;
      logic [3:0]              comma_mask;
      logic [WORD_W-1:0]       left_word_in;
      logic [WORD_W-1:0]       right_word_in;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]       right_digits;
      logic [WORD_W-1:0]       left_digits;
      logic [SCREEN_IDX_W-1:0] screen_shown;
   } rsp_type;

   typedef struct packed {
      logic              hit;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } glyph_type;

   // Font lookup: the A code is used at positions 0 and 2, the B code at 1 and 3.
   // A null or unmapped character gives no hit.
   function automatic glyph_type font_lookup(input logic [CHAR_W-1:0] c);
      glyph_type g;
      g.hit = 1'b1;
      case (c)
         8'h2D:   begin g.a = 16'h0100; g.b = 16'h8000; end
         8'h20:   begin g.a = 16'h0000; g.b = 16'h0000; end
         8'h30:   begin g.a = 16'h0E70; g.b = 16'h700E; end
         8'h31:   begin g.a = 16'h0840; g.b = 16'h1002; end
         8'h32:   begin g.a = 16'h0B30; g.b = 16'hD00C; end
         8'h33:   begin g.a = 16'h0B50; g.b = 16'hD00A; end
         8'h34:   begin g.a = 16'h0D40; g.b = 16'hB002; end
         8'h35:   begin g.a = 16'h0750; g.b = 16'hE00A; end
         8'h36:   begin g.a = 16'h0770; g.b = 16'hE00E; end
         8'h37:   begin g.a = 16'h0A40; g.b = 16'h5002; end
         8'h38:   begin g.a = 16'h0F70; g.b = 16'hF00E; end
         8'h39:   begin g.a = 16'h0F50; g.b = 16'hF00A; end
         8'h41:   begin g.a = 16'h0FE0; g.b = 16'hF006; end
         8'h43:   begin g.a = 16'h0630; g.b = 16'h600C; end
         8'h45:   begin g.a = 16'h0730; g.b = 16'hE00C; end
         8'h46:   begin g.a = 16'h0720; g.b = 16'hE004; end
         8'h48:   begin g.a = 16'h0D60; g.b = 16'hB006; end
         8'h49:   begin g.a = 16'h0840; g.b = 16'h1002; end
         8'h4A:   begin g.a = 16'h0850; g.b = 16'h100A; end
         8'h4C:   begin g.a = 16'h0430; g.b = 16'h200C; end
         8'h50:   begin g.a = 16'h0F20; g.b = 16'hF004; end
         8'h55:   begin g.a = 16'h0C70; g.b = 16'h300E; end
         8'h62:   begin g.a = 16'h0570; g.b = 16'hA00E; end
         8'h64:   begin g.a = 16'h0970; g.b = 16'h900E; end
         8'h68:   begin g.a = 16'h0560; g.b = 16'hA006; end
         8'h69:   begin g.a = 16'h0040; g.b = 16'h0002; end
         8'h6C:   begin g.a = 16'h0420; g.b = 16'h2004; end
         8'h6E:   begin g.a = 16'h0160; g.b = 16'h8006; end
         8'h6F:   begin g.a = 16'h0170; g.b = 16'h800E; end
         8'h75:   begin g.a = 16'h0070; g.b = 16'h000E; end
         default: begin g.hit = 1'b0; g.a = '0; g.b = '0; end
      endcase
      return g;
   endfunction

endpackage

/* hw/rtl/segment_screen_rotator.sv */
// Top level of the segment screen rotator: screen store, rotation and dwell control.
// Depends on ssr_pkg and ssr_font.
//
// The block takes one command word in every cycle and never raises busy. A command is
// registered at the edge where it is accepted and applied at the next edge. A tick's
// result word passes through the input register and the result register around one
// pass of font and rotation logic and shows on rsp for exactly one cycle, marked by
// rsp_valid. Only a tick that finds a non-empty screen gives a result; screen writes
// and ticks on an empty rotation give none.
// The receiver must take each result in the cycle it appears.
module segment_screen_rotator import ssr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req,
   output logic                 rsp_valid,
   output rsp_type              rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DWELL_W-1:0]   csr_wdata
);

   logic                    item_valid_ff;
   req_type                 item_ff;
   logic [WORD_W-1:0]       left_ff  [NUM_SCREENS];
   logic [WORD_W-1:0]       right_ff [NUM_SCREENS];
   logic [WORD_W-1:0]       left_in, right_in;
   logic [SCREEN_IDX_W-1:0] current_ff, current_in;
   logic [DWELL_W-1:0]      dwell_count_ff, dwell_count_in;
   logic [DWELL_W-1:0]      dwell_ff [NUM_SCREENS];
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [NUM_SCREENS-1:0]  empty;
   logic                    is_tick, write_en, sel_ok, show, match;
   logic [SCREEN_IDX_W-1:0] cur_start, cur_shown, rd_addr, cur_next;
   logic [WORD_W-1:0]       rd_left, rd_right, font_left, font_right;
   logic [DWELL_W-1:0]      limit, count_inc;

   assign busy = 1'b0;

   always_comb begin
      for (int i = 0; i < NUM_SCREENS; i++) begin
         empty[i] = ~|{left_ff[i], right_ff[i]};
      end
   end

   // Rotation: an empty current screen is skipped once before the look at the store.
   always_comb begin
      is_tick   = (item_ff.op == OP_TICK);
      cur_start = (current_ff < SCREEN_IDX_W'(NUM_SCREENS)) ? current_ff : '0;
      cur_shown = cur_start;
      if (empty[cur_start]) begin
         cur_shown = (cur_start + 1'b1 >= SKIP_WRAP) ? '0 : cur_start + 1'b1;
      end
      show     = !empty[cur_shown];
      cur_next = (cur_shown == SCREEN_IDX_W'(NUM_SCREENS - 1)) ? '0 : cur_shown + 1'b1;
      sel_ok   = (item_ff.screen_sel < SCREEN_IDX_W'(NUM_SCREENS));
      write_en = item_valid_ff && !is_tick && sel_ok;
      rd_addr  = is_tick ? cur_shown : item_ff.screen_sel;
   end

   always_comb begin
      rd_left  = '0;
      rd_right = '0;
      limit    = dwell_ff[0];
      for (int i = 0; i < NUM_SCREENS; i++) begin
         if (rd_addr == SCREEN_IDX_W'(i)) begin
            rd_left  = left_ff[i];
            rd_right = right_ff[i];
         end
         if (cur_shown == SCREEN_IDX_W'(i)) begin
            limit = dwell_ff[i];
         end
      end
      count_inc = dwell_count_ff + 1'b1;
      match     = (count_inc == limit);
   end

   ssr_font u_font (
      .item      (item_ff),
      .old_left  (rd_left),
      .old_right (rd_right),
      .new_left  (font_left),
      .new_right (font_right)
   );

   always_comb begin
      case (item_ff.op)
         OP_SET_CHARS: begin left_in = font_left;          right_in = font_right;          end
         OP_SET_RAW:   begin left_in = item_ff.left_word_in; right_in = item_ff.right_word_in; end
         default:      begin left_in = '0;                 right_in = '0;                  end
      endcase
   end

   always_comb begin
      current_in     = current_ff;
      dwell_count_in = dwell_count_ff;
      rsp_valid_in   = 1'b0;
      if (item_valid_ff && is_tick) begin
         current_in = cur_shown;
         if (show) begin
            rsp_valid_in   = 1'b1;
            dwell_count_in = match ? '0 : count_inc;
            if (match) begin
               current_in = cur_next;
            end
         end
      end
      rsp_in.right_digits = rd_right;
      rsp_in.left_digits  = rd_left;
      rsp_in.screen_shown = cur_shown;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff  <= 1'b0;
         current_ff     <= '0;
         dwell_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_SCREENS; i++) begin
            left_ff[i]  <= '0;
            right_ff[i] <= '0;
            dwell_ff[i] <= DWELL_RESET;
         end
      end else begin
         item_valid_ff  <= start;
         current_ff     <= current_in;
         dwell_count_ff <= dwell_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         for (int i = 0; i < NUM_SCREENS; i++) begin
            if (write_en && item_ff.screen_sel == SCREEN_IDX_W'(i)) begin
               left_ff[i]  <= left_in;
               right_ff[i] <= right_in;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DWELL_FIRST:  dwell_ff[0] <= csr_wdata;
               CSR_DWELL_SECOND: dwell_ff[1] <= csr_wdata;
               CSR_DWELL_THIRD:  dwell_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= req;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* hw/rtl/ssr_font.sv */
// Character encoder for one screen: turns four characters and a comma mask into
// the two segment halves, starting from the halves already stored. Uses ssr_pkg.
module ssr_font import ssr_pkg::*; (
   input  req_type           item,
   input  logic [WORD_W-1:0] old_left,
   input  logic [WORD_W-1:0] old_right,
   output logic [WORD_W-1:0] new_left,
   output logic [WORD_W-1:0] new_right
);

   glyph_type g0, g1, g2, g3;
   logic [WORD_W-1:0] left_a, right_a;

   always_comb begin
      g0 = font_lookup(item.char0);
      g1 = font_lookup(item.char1);
      g2 = font_lookup(item.char2);
      g3 = font_lookup(item.char3);

      // An unmapped character leaves its half as it was.
      left_a  = g0.hit ? g0.a : old_left;
      right_a = g2.hit ? g2.a : old_right;

      new_left  = left_a  | (g1.hit ? g1.b : '0)
                          | (item.comma_mask[0] ? COMMA_A : '0)
                          | (item.comma_mask[1] ? COMMA_B : '0);
      new_right = right_a | (g3.hit ? g3.b : '0)
                          | (item.comma_mask[2] ? COMMA_A : '0)
                          | (item.comma_mask[3] ? COMMA_B : '0);
   end

endmodule

/* hw/rtl/ssr_checker.sv */
// Port-level checker for the segment screen rotator, bound to the top level below.
// Depends on ssr_pkg and segment_screen_rotator.
module ssr_port_props import ssr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req,
   input logic    rsp_valid,
   input rsp_type rsp
);

   // A result word only ever follows a tick that went through the input and result registers.
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start, 2) && $past(req.op, 2) == OP_TICK))
      else $error("result word without a tick two cycles earlier");

   a_screen_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.screen_shown < SCREEN_IDX_W'(NUM_SCREENS))
      else $error("result shows a screen index out of range");

   // Back-to-back results cannot jump from the first screen to the third.
   a_no_jump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && $past(rsp.screen_shown) == '0)
         |-> rsp.screen_shown != SCREEN_IDX_W'(2))
      else $error("rotation jumped from the first screen to the third");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> !busy)
      else $error("block raised busy");

endmodule

bind segment_screen_rotator ssr_port_props u_ssr_port_props (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);

/* sim/ssr_checker.sv */
// Checker for the segment screen rotator: watches the command, result and register ports,
// keeps its own copy of the screens and rotation state and compares every display word.
// Depends on ssr_pkg for the payload structs, op codes and register indexes.
module ssr_checker import ssr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req,
   input  logic                 rsp_valid,
   input  rsp_type              rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DWELL_W-1:0]   csr_wdata,
   output int                   fail_count,
   output int                   pending,
   output int                   frames_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // Font tables, entry 0 in the most significant slot.
   localparam logic [10*16-1:0] DIGIT_A = {
      16'h0E70, 16'h0840, 16'h0B30, 16'h0B50, 16'h0D40,
      16'h0750, 16'h0770, 16'h0A40, 16'h0F70, 16'h0F50};
   localparam logic [10*16-1:0] DIGIT_B = {
      16'h700E, 16'h1002, 16'hD00C, 16'hD00A, 16'hB002,
      16'hE00A, 16'hE00E, 16'h5002, 16'hF00E, 16'hF00A};
   localparam logic [18*8-1:0] LETTERS = "ACEFHIJLPUbdhilnou";
   localparam logic [18*16-1:0] LETTER_A = {
      16'h0FE0, 16'h0630, 16'h0730, 16'h0720, 16'h0D60, 16'h0840, 16'h0850, 16'h0430,
      16'h0F20, 16'h0C70, 16'h0570, 16'h0970, 16'h0560, 16'h0040, 16'h0420, 16'h0160,
      16'h0170, 16'h0070};
   localparam logic [18*16-1:0] LETTER_B = {
      16'hF006, 16'h600C, 16'hE00C, 16'hE004, 16'hB006, 16'h1002, 16'h100A, 16'h200C,
      16'hF004, 16'h300E, 16'hA00E, 16'h900E, 16'hA006, 16'h0002, 16'h2004, 16'h8006,
      16'h800E, 16'h000E};

   logic [WORD_W-1:0]       screen_left  [NUM_SCREENS];
   logic [WORD_W-1:0]       screen_right [NUM_SCREENS];
   logic [DWELL_W-1:0]      dwell_limit  [NUM_SCREENS];
   logic [SCREEN_IDX_W-1:0] shown_idx;
   logic [DWELL_W-1:0]      dwell_ticks;
   rsp_type                 frames_due [$];
   int                      mismatches = 0;
   int                      due_count  = 0;
   int                      compared   = 0;

   assign fail_count     = mismatches;
   assign pending        = due_count;
   assign frames_checked = compared;

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("mismatch at %0t ns: %s, got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic bit glyph_codes(input logic [CHAR_W-1:0] ch,
                                      output logic [WORD_W-1:0] a,
                                      output logic [WORD_W-1:0] b);
      a = '0;
      b = '0;
      if (ch == 8'h00) return 1'b0;
      if (ch == "-") begin
         a = 16'h0100;
         b = 16'h8000;
         return 1'b1;
      end
      if (ch == " ") return 1'b1;
      if (ch >= "0" && ch <= "9") begin
         a = DIGIT_A[(9 - (ch - "0")) * 16 +: 16];
         b = DIGIT_B[(9 - (ch - "0")) * 16 +: 16];
         return 1'b1;
      end
      for (int i = 0; i < 18; i++) begin
         if (LETTERS[(17 - i) * 8 +: 8] == ch) begin
            a = LETTER_A[(17 - i) * 16 +: 16];
            b = LETTER_B[(17 - i) * 16 +: 16];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit screen_blank(input logic [SCREEN_IDX_W-1:0] idx);
      return screen_left[idx] == '0 && screen_right[idx] == '0;
   endfunction

   // Applies one command word to the shadow state; returns 1 with the display word
   // that a tick should produce.
   function automatic bit predict_display(input req_type w, output rsp_type frame);
      logic [SCREEN_IDX_W-1:0] idx;
      logic [WORD_W-1:0]       a;
      logic [WORD_W-1:0]       b;
      frame = '0;
      idx   = w.screen_sel;
      if (w.op != OP_TICK) begin
         if (idx < NUM_SCREENS) begin
            case (w.op)
               OP_SET_CHARS: begin
                  if (glyph_codes(w.char0, a, b)) screen_left[idx] = a;
                  if (glyph_codes(w.char1, a, b)) screen_left[idx] = screen_left[idx] | b;
                  if (glyph_codes(w.char2, a, b)) screen_right[idx] = a;
                  if (glyph_codes(w.char3, a, b)) screen_right[idx] = screen_right[idx] | b;
                  if (w.comma_mask[0]) screen_left[idx]  = screen_left[idx]  | COMMA_A;
                  if (w.comma_mask[1]) screen_left[idx]  = screen_left[idx]  | COMMA_B;
                  if (w.comma_mask[2]) screen_right[idx] = screen_right[idx] | COMMA_A;
                  if (w.comma_mask[3]) screen_right[idx] = screen_right[idx] | COMMA_B;
               end
               OP_SET_RAW: begin
                  screen_left[idx]  = w.left_word_in;
                  screen_right[idx] = w.right_word_in;
               end
               default: begin
                  screen_left[idx]  = '0;
                  screen_right[idx] = '0;
               end
            endcase
         end
         return 1'b0;
      end

      idx = shown_idx;
      if (idx >= NUM_SCREENS) idx = '0;
      // An empty screen is skipped only once, and that skip wraps at SKIP_WRAP rather
      // than at the screen count, so screen 2 is only reached through a dwell match.
      if (screen_blank(idx)) idx = (idx + 1 >= SKIP_WRAP) ? '0 : idx + 2'd1;
      shown_idx = idx;
      if (screen_blank(idx)) return 1'b0;

      frame.right_digits = screen_right[idx];
      frame.left_digits  = screen_left[idx];
      frame.screen_shown = idx;
      dwell_ticks = dwell_ticks + 8'd1;
      if (dwell_ticks == dwell_limit[idx]) begin
         dwell_ticks = '0;
         shown_idx   = (idx + 1 >= NUM_SCREENS) ? '0 : idx + 2'd1;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type frame;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SCREENS; i++) begin
            screen_left[i]  = '0;
            screen_right[i] = '0;
            dwell_limit[i]  = DWELL_RESET;
         end
         shown_idx   = '0;
         dwell_ticks = '0;
         frames_due.delete();
      end else begin
         if (rsp_valid) begin
            if (frames_due.size() == 0) begin
               report_mismatch("display word with none expected", rsp.right_digits, '0);
            end else begin
               want = frames_due.pop_front();
               if (rsp.right_digits !== want.right_digits)
                  report_mismatch("right_digits", rsp.right_digits, want.right_digits);
               if (rsp.left_digits !== want.left_digits)
                  report_mismatch("left_digits", rsp.left_digits, want.left_digits);
               if (rsp.screen_shown !== want.screen_shown)
                  report_mismatch("screen_shown", rsp.screen_shown, want.screen_shown);
               compared++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DWELL_FIRST:  dwell_limit[0] = csr_wdata;
               CSR_DWELL_SECOND: dwell_limit[1] = csr_wdata;
               CSR_DWELL_THIRD:  dwell_limit[2] = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (predict_display(req, frame)) frames_due.push_back(frame);
         end
      end
      due_count = frames_due.size();
   end

endmodule

/* sim/tb_top.sv */
// Top of the segment screen rotator testbench: clock, reset, command and register stimulus.
// Depends on ssr_pkg, the segment_screen_rotator RTL and the ssr_checker module.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ssr_pkg::*;

   localparam int PHASE_WORDS = 280;
   // Every character the font knows, space and dash included.
   localparam logic [30*8-1:0] MAPPED = "- 0123456789ACEFHIJLPUbdhilnou";

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req;
   logic                 rsp_valid;
   rsp_type              rsp;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DWELL_W-1:0]   csr_wdata;
   int                   fail_count;
   int                   pending;
   int                   frames_checked;

   bit idle_on     = 1'b1;
   int words_sent  = 0;
   int ticks_sent  = 0;
   int settings    = 0;

   segment_screen_rotator u_dut (
      .clock, .reset, .start, .busy, .req, .rsp_valid, .rsp,
      .csr_we, .csr_index, .csr_wdata
   );

   ssr_checker u_checker (
      .clock, .reset, .start, .busy, .req, .rsp_valid, .rsp,
      .csr_we, .csr_index, .csr_wdata, .fail_count, .pending, .frames_checked
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

   function automatic req_type make_cmd(input op_type op, input logic [1:0] sel,
                                        input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [7:0] c3,
                                        input logic [3:0] mask, input logic [15:0] lw,
                                        input logic [15:0] rw);
      req_type w;
      w.op            = op;
      w.screen_sel    = sel;
      w.char0         = c0;
      w.char1         = c1;
      w.char2         = c2;
      w.char3         = c3;
      w.comma_mask    = mask;
      w.left_word_in  = lw;
      w.right_word_in = rw;
      return w;
   endfunction

   function automatic logic [7:0] pick_char();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return 8'h00;
      if (roll < 25) return 8'($urandom_range(255));
      return MAPPED[$urandom_range(29) * 8 +: 8];
   endfunction

   function automatic req_type random_word();
      req_type     w;
      int unsigned roll;
      roll = $urandom_range(99);
      w.op = (roll < 55) ? OP_TICK : (roll < 75) ? OP_SET_CHARS :
             (roll < 90) ? OP_SET_RAW : OP_CLEAR;
      w.screen_sel    = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      w.char0         = pick_char();
      w.char1         = pick_char();
      w.char2         = pick_char();
      w.char3         = pick_char();
      w.comma_mask    = 4'($urandom_range(15));
      w.left_word_in  = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
      w.right_word_in = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
      return w;
   endfunction

   task automatic send_word(input req_type w);
      while (idle_on && $urandom_range(99) < 22) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req   <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
      if (w.op == OP_TICK) ticks_sent++;
   endtask

   task automatic send_tick();
      send_word(make_cmd(OP_TICK, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 16'h0, 16'h0));
   endtask

   // Holds the sender off until the checker expects nothing more, then lets the
   // block's input and result registers empty out after any word that gave no result.
   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_dwells(input logic [7:0] d0, input logic [7:0] d1,
                             input logic [7:0] d2);
      csr_we    <= 1'b1;
      csr_index <= CSR_DWELL_FIRST;
      csr_wdata <= d0;
      @(posedge clock);
      csr_index <= CSR_DWELL_SECOND;
      csr_wdata <= d1;
      @(posedge clock);
      csr_index <= CSR_DWELL_THIRD;
      csr_wdata <= d2;
      @(posedge clock);
      csr_we <= 1'b0;
      settings++;
   endtask

   initial begin
      logic [7:0] d0;
      logic [7:0] d1;
      logic [7:0] d2;
      reset     = 1'b1;
      start     = 1'b0;
      req       = '0;
      csr_we    = 1'b0;
      csr_index = CSR_DWELL_FIRST;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_dwells(8'd1, 8'd2, 8'd3);
      // Ticks on an empty rotation give nothing.
      send_tick();
      send_tick();
      send_word(make_cmd(OP_SET_CHARS, 2'd0, "8", "8", "8", "8", 4'hF, 16'h0, 16'h0));
      send_tick();
      send_word(make_cmd(OP_SET_CHARS, 2'd3, "A", "b", "C", "d", 4'hF, 16'h0, 16'h0));
      send_word(make_cmd(OP_SET_RAW, 2'd1, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0,
                         16'hFFFF, 16'hFFFF));
      send_word(make_cmd(OP_SET_RAW, 2'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF,
                         16'h0001, 16'h8000));
      // Null, dash, unmapped and space on a full screen.
      send_word(make_cmd(OP_SET_CHARS, 2'd1, 8'h00, "-", 8'hFF, " ", 4'h0, 16'h0, 16'h0));
      repeat (6) send_tick();
      send_word(make_cmd(OP_CLEAR, 2'd1, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 16'h0, 16'h0));
      send_word(make_cmd(OP_CLEAR, 2'd3, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 16'h0, 16'h0));
      send_word(make_cmd(OP_SET_RAW, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0,
                         16'h0000, 16'h0000));
      // Both of the first two screens empty: skipping once still finds nothing.
      repeat (3) send_tick();
      send_word(make_cmd(OP_SET_CHARS, 2'd0, "H", "E", "L", "P", 4'h1, 16'h0, 16'h0));
      send_word(make_cmd(OP_SET_CHARS, 2'd1, "0", "u", "9", "n", 4'hA, 16'h0, 16'h0));
      repeat (4) send_tick();
      drain_results();

      // A dwell of zero only matches once the counter wraps round.
      set_dwells(8'd0, 8'd1, 8'd1);
      send_word(make_cmd(OP_SET_RAW, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0,
                         16'h1234, 16'hABCD));
      send_word(make_cmd(OP_SET_RAW, 2'd2, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0,
                         16'h8001, 16'h7FFE));
      repeat (300) send_tick();
      drain_results();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin d0 = 8'd1;   d1 = 8'd1;   d2 = 8'd1;   end
            1: begin d0 = 8'd255; d1 = 8'd255; d2 = 8'd255; end
            2: begin
               d0 = 8'($urandom_range(1, 6));
               d1 = 8'($urandom_range(1, 6));
               d2 = 8'($urandom_range(1, 6));
            end
            3: begin d0 = 8'd2;   d1 = 8'd7;   d2 = 8'd4;   end
            default: begin
               d0 = 8'($urandom_range(1, 255));
               d1 = 8'($urandom_range(1, 12));
               d2 = 8'($urandom_range(1, 12));
            end
         endcase
         set_dwells(d0, d1, d2);
         idle_on = (phase != 2);
         for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word());
         drain_results();
      end

      $display("Drove %0d command words, %0d of them ticks, under %0d dwell settings;",
               words_sent, ticks_sent, settings);
      $display("%0d display words were compared.", frames_checked);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
